// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Sizes, codes, beat types and word conversions of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Storage geometry.
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Capacity register.
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation queue between the front and back parts; a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Value reported at both ends when the deque is empty.
  localparam logic signed [31:0] NONE_VALUE = -32'sd1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [CAP_W-1:0]      cap_t;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_BACK  = 2'd1,
    ACT_REM_FRONT = 2'd2,
    ACT_REM_BACK  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } bdq_out_t;

  // Classified operation handed from the front part to the back part.
  typedef struct packed {
    logic  insert;
    logic  at_front;
    word_t data;
  } bdq_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bdq_q_status_t;

  // Keep the low DATA_WIDTH bits of a sign-extended input word.
  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word and report its low 32 bits.
  function automatic logic signed [31:0] from_word(word_t w);
    logic signed [63:0] wide;
    wide = 64'(signed'(w));
    return wide[31:0];
  endfunction

endpackage

// ===== hdl/bdq_front.sv =====
// ----------------------------------------------------------------------------
// bdq_front
// Accepts input beats, classifies the action and pushes it to the op queue.
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bdq_pkg::bdq_in_t       in_data,
  input  bdq_pkg::bdq_q_status_t q_status,
  output logic                   op_push,
  output bdq_pkg::bdq_op_t       push_op
);
  import bdq_pkg::*;

  logic    stage_valid_r;
  logic    stage_valid_nxt;
  bdq_op_t stage_op_r;
  bdq_op_t stage_op_nxt;
  logic    in_take;

  // The stage is free when empty or when its op moves on this cycle.
  assign op_push  = stage_valid_r && !q_status.full;
  assign in_stall = stage_valid_r && q_status.full;
  assign in_take  = in_valid && !in_stall;
  assign push_op  = stage_op_r;

  // Decode the action into insert/remove and front/back.
  always_comb begin
    stage_op_nxt      = stage_op_r;
    stage_valid_nxt   = stage_valid_r && !op_push;
    if (in_take) begin
      stage_valid_nxt = 1'b1;
      stage_op_nxt.data = to_word(in_data.value);
      case (in_data.action)
        ACT_INS_FRONT: begin
          stage_op_nxt.insert   = 1'b1;
          stage_op_nxt.at_front = 1'b1;
        end
        ACT_INS_BACK: begin
          stage_op_nxt.insert   = 1'b1;
          stage_op_nxt.at_front = 1'b0;
        end
        ACT_REM_FRONT: begin
          stage_op_nxt.insert   = 1'b0;
          stage_op_nxt.at_front = 1'b1;
        end
        default: begin
          stage_op_nxt.insert   = 1'b0;
          stage_op_nxt.at_front = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_op_r <= stage_op_nxt;
  end

endmodule

// ===== hdl/bdq_op_fifo.sv =====
// ----------------------------------------------------------------------------
// bdq_op_fifo
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module bdq_op_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   op_push,
  input  bdq_pkg::bdq_op_t       push_op,
  input  logic                   op_pop,
  output bdq_pkg::bdq_op_t       head_op,
  output bdq_pkg::bdq_q_status_t q_status
);
  import bdq_pkg::*;

  bdq_op_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   fill_r;
  logic [QCNT_W-1:0]   fill_nxt;

  assign head_op        = slots[rd_ptr_r];
  assign q_status.full  = fill_r == QCNT_W'(QDEPTH);
  assign q_status.empty = fill_r == '0;

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = op_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = op_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (op_push && !op_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (op_pop && !op_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (op_push) begin
      slots[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== hdl/bdq_back.sv =====
// ----------------------------------------------------------------------------
// bdq_back
// Executes queued operations on the circular store and forms result beats.
// ----------------------------------------------------------------------------
module bdq_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bdq_pkg::cap_t          capacity,
  input  bdq_pkg::bdq_op_t       op,
  input  bdq_pkg::bdq_q_status_t q_status,
  output logic                   op_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bdq_pkg::bdq_out_t      out_data
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_t;

  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  // Add two slot indexes modulo DEPTH; the sum stays below twice DEPTH.
  function automatic addr_t wrap_add(addr_t base, addr_t offs);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  state_t     state_r;
  state_t     state_nxt;
  addr_t      head_r;
  addr_t      head_nxt;
  count_t     count_r;
  count_t     count_nxt;
  logic       acc_r;
  logic       acc_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  bdq_out_t   out_data_r;
  bdq_out_t   out_data_nxt;

  word_t      store [DEPTH];
  word_t      rd_front_r;
  word_t      rd_rear_r;
  logic       mem_we;
  addr_t      mem_waddr;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] depth_c;
  logic [CMP_W-1:0] limit;
  logic       is_full;
  logic       is_empty;
  addr_t      head_dec;
  addr_t      head_inc;
  addr_t      tail_addr;
  addr_t      rear_addr;

  // Occupancy flags against the clamped capacity.
  assign cap_ext  = CMP_W'(capacity);
  assign depth_c  = CMP_W'(DEPTH);
  assign limit    = (cap_ext > depth_c) ? depth_c : cap_ext;
  assign is_full  = CMP_W'(count_r) >= limit;
  assign is_empty = count_r == '0;

  // Neighbor slots of the head, the free slot past the rear, and the rear.
  assign head_dec  = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc  = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_addr = wrap_add(head_r, ADDR_W'(count_r));
  assign rear_addr = wrap_add(head_r, ADDR_W'(count_r - 1'b1));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: execute, read both ends, then load the result register.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    op_pop        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = tail_addr;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_EXEC: begin
        if (!q_status.empty) begin
          op_pop    = 1'b1;
          acc_nxt   = 1'b0;
          state_nxt = ST_READ;
          if (op.insert) begin
            if (!is_full) begin
              acc_nxt   = 1'b1;
              count_nxt = count_r + 1'b1;
              mem_we    = 1'b1;
              if (op.at_front) begin
                head_nxt  = head_dec;
                mem_waddr = head_dec;
              end
            end
          end else if (!is_empty) begin
            acc_nxt   = 1'b1;
            count_nxt = count_r - 1'b1;
            if (op.at_front) begin
              head_nxt = head_inc;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.accepted    = acc_r;
          out_data_nxt.front_value = is_empty ? NONE_VALUE : from_word(rd_front_r);
          out_data_nxt.rear_value  = is_empty ? NONE_VALUE : from_word(rd_rear_r);
          out_data_nxt.is_empty    = is_empty;
          out_data_nxt.is_full     = is_full;
          state_nxt                = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entry store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= op.data;
    end
    if (state_r == ST_READ) begin
      rd_front_r <= store[head_r];
      rd_rear_r  <= store[rear_addr];
    end
  end

endmodule

// ===== hdl/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// A deque of signed words in a circular store of bdq_pkg::DEPTH entries,
// limited by the capacity register (clamped to the depth). Each input beat
// inserts or removes at either end; a refused operation leaves the state
// alone. Every input beat yields one result beat with the accepted flag,
// both end words after the operation (-1 when empty) and the empty and full
// flags. An input beat passes a registered classify stage and a two-entry
// operation queue, then the execute sequencer: update pointers and write
// the store, read both ends from the store, load the result register. The
// sequencer takes no new operation until it has loaded the result of the
// last one, so it and its single store bound the throughput. Write
// capacity only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdq_pkg::bdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bdq_pkg::bdq_out_t out_data,
  input  logic              cfg_we,
  input  bdq_pkg::cap_t     cfg_data
);
  import bdq_pkg::*;

  cap_t          capacity_r;
  logic          op_push;
  bdq_op_t       push_op;
  logic          op_pop;
  bdq_op_t       head_op;
  bdq_q_status_t q_status;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_data;
    end
  end

  bdq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .op_push  (op_push),
    .push_op  (push_op)
  );

  bdq_op_fifo u_op_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_push  (op_push),
    .push_op  (push_op),
    .op_pop   (op_pop),
    .head_op  (head_op),
    .q_status (q_status)
  );

  bdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .op        (head_op),
    .q_status  (q_status),
    .op_pop    (op_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Checks on the op queue handoff and the result beat.
  `ASSERT_SAME(a_push_has_room, op_push, !q_status.full, "op pushed into a full queue")
  `ASSERT_SAME(a_pop_has_op, op_pop, !q_status.empty, "op popped from an empty queue")
  `ASSERT_NEXT(a_empty_stays, q_status.empty && !op_push, q_status.empty, "queue filled without a push")
  `ASSERT_SAME(a_empty_ends, out_valid && out_data.is_empty, (out_data.front_value == NONE_VALUE) && (out_data.rear_value == NONE_VALUE), "empty result with end words")

endmodule
